/* design/fmm_pkg.sv */
// Shared types, codes and field widths for the temperature FIFO with minimum and mean.
package fmm_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int TEMP_W   = 16;
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;

   localparam int REQ_FIELDS_W = TEMP_W + DAY_W + MONTH_W;
   localparam int REQ_TDATA_W  = 32;
   localparam int RSP_FIELDS_W = 3 * TEMP_W + DAY_W + MONTH_W;
   localparam int RSP_TDATA_W  = 64;

   localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_MIN  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_MEAN = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic [DAY_W-1:0]         day;
      logic [MONTH_W-1:0]       month;
   } rec_type;

   typedef enum logic [2:0] {
      KIND_OK,
      KIND_FULL,
      KIND_EMPTY,
      KIND_POP,
      KIND_MIN,
      KIND_MEAN
   } out_kind_type;

   typedef struct packed {
      logic         push;
      logic         pop_read;
      logic         pop_done;
      logic         scan_start;
      logic         scan_step;
      logic         div_start;
      logic         div_step;
      logic         out_load;
      out_kind_type out_kind;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic scan_last;
      logic div_last;
   } sts_type;

endpackage

/* design/fmm_dpath.sv */
// Datapath: record memory, ring pointers, running sum, minimum scan, divider, result registers.
module fmm_dpath #(
   parameter int DEPTH = fmm_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fmm_pkg::cmd_type                     cmd,
   output fmm_pkg::sts_type                     sts,
   input  logic signed [fmm_pkg::TEMP_W-1:0]    temperature_in,
   input  logic [fmm_pkg::DAY_W-1:0]            day_in,
   input  logic [fmm_pkg::MONTH_W-1:0]          month_in,
   output logic [fmm_pkg::STATUS_W-1:0]         status,
   output logic signed [fmm_pkg::TEMP_W-1:0]    temperature_out,
   output logic [fmm_pkg::DAY_W-1:0]            day_out,
   output logic [fmm_pkg::MONTH_W-1:0]          month_out,
   output logic signed [fmm_pkg::TEMP_W-1:0]    minimum,
   output logic signed [fmm_pkg::TEMP_W-1:0]    mean
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = fmm_pkg::TEMP_W + CNT_W;
   localparam int DCNT_W = $clog2(SUM_W + 1);
   localparam int TW     = fmm_pkg::TEMP_W;

   fmm_pkg::rec_type mem [DEPTH];
   fmm_pkg::rec_type rd_data_ff;
   fmm_pkg::rec_type wr_rec;

   logic [PTR_W-1:0]        head_ff, head_in;
   logic [PTR_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   logic [PTR_W-1:0]        scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0]        scan_left_ff, scan_left_in;
   logic                    scan_first_ff, scan_first_in;
   logic signed [TW-1:0]    min_ff, min_in;

   logic [SUM_W-1:0]        dvd_ff, dvd_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [DCNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic                    neg_ff, neg_in;
   logic [CNT_W:0]          trial;
   logic                    trial_ge;
   logic [TW-1:0]           quo_low;

   logic                    rd_en;
   logic [PTR_W-1:0]        rd_addr;

   logic [fmm_pkg::STATUS_W-1:0] status_ff, status_in;
   logic signed [TW-1:0]         temp_out_ff, temp_out_in;
   logic [fmm_pkg::DAY_W-1:0]    day_out_ff, day_out_in;
   logic [fmm_pkg::MONTH_W-1:0]  month_out_ff, month_out_in;
   logic signed [TW-1:0]         min_out_ff, min_out_in;
   logic signed [TW-1:0]         mean_out_ff, mean_out_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wr_rec.temp  = temperature_in;
   assign wr_rec.day   = day_in;
   assign wr_rec.month = month_in;

   assign sts.empty     = (count_ff == '0);
   assign sts.full      = (count_ff == CNT_W'(DEPTH));
   assign sts.scan_last = (scan_left_ff == '0);
   assign sts.div_last  = (div_cnt_ff == DCNT_W'(1));

   // one restoring step: shift in the next dividend bit, subtract when it fits
   assign trial    = {rem_ff, dvd_ff[SUM_W-1]};
   assign trial_ge = (trial >= {1'b0, count_ff});
   assign quo_low  = dvd_ff[TW-1:0];

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      scan_addr_in  = scan_addr_ff;
      scan_left_in  = scan_left_ff;
      scan_first_in = scan_first_ff;
      min_in        = min_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      neg_in        = neg_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff;

      if (cmd.push) begin
         tail_in  = next_ptr(tail_ff);
         count_in = count_ff + 1'b1;
         sum_in   = sum_ff + SUM_W'(temperature_in);
      end

      if (cmd.pop_read) begin
         rd_en = 1'b1;
      end

      if (cmd.pop_done) begin
         head_in  = next_ptr(head_ff);
         count_in = count_ff - 1'b1;
         sum_in   = sum_ff - SUM_W'(rd_data_ff.temp);
      end

      if (cmd.scan_start) begin
         rd_en         = 1'b1;
         scan_addr_in  = next_ptr(head_ff);
         scan_left_in  = count_ff - 1'b1;
         scan_first_in = 1'b1;
      end

      // fold the word read last cycle, fetch the next while any remain
      if (cmd.scan_step) begin
         scan_first_in = 1'b0;
         if (scan_first_ff || (rd_data_ff.temp < min_ff)) begin
            min_in = rd_data_ff.temp;
         end
         if (scan_left_ff != '0) begin
            rd_en        = 1'b1;
            rd_addr      = scan_addr_ff;
            scan_addr_in = next_ptr(scan_addr_ff);
            scan_left_in = scan_left_ff - 1'b1;
         end
      end

      if (cmd.div_start) begin
         neg_in     = sum_ff[SUM_W-1];
         dvd_in     = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
         rem_in     = '0;
         div_cnt_in = DCNT_W'(SUM_W);
      end

      if (cmd.div_step) begin
         dvd_in     = {dvd_ff[SUM_W-2:0], trial_ge};
         rem_in     = trial_ge ? CNT_W'(trial - {1'b0, count_ff}) : trial[CNT_W-1:0];
         div_cnt_in = div_cnt_ff - 1'b1;
      end
   end

   always_comb begin
      status_in    = fmm_pkg::STATUS_OK;
      temp_out_in  = '0;
      day_out_in   = '0;
      month_out_in = '0;
      min_out_in   = '0;
      mean_out_in  = '0;
      case (cmd.out_kind)
         fmm_pkg::KIND_FULL:  status_in = fmm_pkg::STATUS_FULL;
         fmm_pkg::KIND_EMPTY: status_in = fmm_pkg::STATUS_EMPTY;
         fmm_pkg::KIND_POP: begin
            temp_out_in  = rd_data_ff.temp;
            day_out_in   = rd_data_ff.day;
            month_out_in = rd_data_ff.month;
         end
         fmm_pkg::KIND_MIN:  min_out_in  = min_ff;
         fmm_pkg::KIND_MEAN: mean_out_in = neg_ff ? -quo_low : quo_low;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         sum_ff        <= '0;
         scan_left_ff  <= '0;
         scan_first_ff <= 1'b0;
         div_cnt_ff    <= '0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         scan_left_ff  <= scan_left_in;
         scan_first_ff <= scan_first_in;
         div_cnt_ff    <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      min_ff       <= min_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      neg_ff       <= neg_in;
      if (cmd.out_load) begin
         status_ff    <= status_in;
         temp_out_ff  <= temp_out_in;
         day_out_ff   <= day_out_in;
         month_out_ff <= month_out_in;
         min_out_ff   <= min_out_in;
         mean_out_ff  <= mean_out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[tail_ff] <= wr_rec;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign status          = status_ff;
   assign temperature_out = temp_out_ff;
   assign day_out         = day_out_ff;
   assign month_out       = month_out_ff;
   assign minimum         = min_out_ff;
   assign mean            = mean_out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_sum_zero_when_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (sum_ff == '0))
      else $error("running sum nonzero with no entries");

   a_ptrs_meet_when_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("head and tail differ with no entries");

endmodule

/* design/fmm_ctrl.sv */
// Controller: sequences push, pop, minimum scan and mean divide, and owns the result valid.
module fmm_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [fmm_pkg::FUNC_W-1:0]   req_func,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output fmm_pkg::cmd_type             cmd,
   input  fmm_pkg::sts_type             sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_MIN,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   fmm_pkg::out_kind_type kind_ff, kind_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      cmd.push       = 1'b0;
      cmd.pop_read   = 1'b0;
      cmd.pop_done   = 1'b0;
      cmd.scan_start = 1'b0;
      cmd.scan_step  = 1'b0;
      cmd.div_start  = 1'b0;
      cmd.div_step   = 1'b0;
      cmd.out_load   = 1'b0;
      cmd.out_kind   = kind_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_FINISH;
               kind_in  = fmm_pkg::KIND_EMPTY;
               unique case (req_func)
                  fmm_pkg::FUNC_PUSH: begin
                     if (sts.full) begin
                        kind_in = fmm_pkg::KIND_FULL;
                     end else begin
                        cmd.push = 1'b1;
                        kind_in  = fmm_pkg::KIND_OK;
                     end
                  end
                  fmm_pkg::FUNC_POP: begin
                     if (!sts.empty) begin
                        cmd.pop_read = 1'b1;
                        state_in     = ST_POP;
                     end
                  end
                  fmm_pkg::FUNC_MIN: begin
                     if (!sts.empty) begin
                        cmd.scan_start = 1'b1;
                        state_in       = ST_MIN;
                     end
                  end
                  fmm_pkg::FUNC_MEAN: begin
                     if (!sts.empty) begin
                        cmd.div_start = 1'b1;
                        state_in      = ST_DIV;
                     end
                  end
               endcase
            end
         end
         ST_POP: begin
            cmd.pop_done = 1'b1;
            kind_in      = fmm_pkg::KIND_POP;
            state_in     = ST_FINISH;
         end
         ST_MIN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               kind_in  = fmm_pkg::KIND_MIN;
               state_in = ST_FINISH;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               kind_in  = fmm_pkg::KIND_MEAN;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= fmm_pkg::KIND_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a word not yet taken");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !sts.full)
      else $error("push issued on a full queue");

   a_no_read_when_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop_read || cmd.scan_start || cmd.div_start) |-> !sts.empty)
      else $error("read operation issued on an empty queue");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && sts.div_last) |=> (state_ff == ST_FINISH))
      else $error("divider finished but controller did not move on");

endmodule

/* design/fifo_with_min_and_mean.sv */
// Top level of the temperature FIFO with minimum and mean queries.
//
// Request channel (req_): req_tuser carries the operation (push, pop, minimum, mean);
// req_tdata carries the record to push (temperature, day, month). A word is taken
// when req_tvalid and req_tready are both high; one operation is in flight at a time.
// Response channel (rsp_): exactly one word per request. rsp_tuser carries the status
// (ok, empty, full); rsp_tdata carries the popped record, the minimum and the mean.
// What each operation does before the edge that raises rsp_tvalid, receiver ready:
//   push, or any rejected operation: goes straight to the finish state
//   pop: one registered memory read
//   minimum: the scan reads one stored record per cycle from the memory
//   mean: restoring divider, one quotient bit per cycle
// The next request is taken as soon as the previous response sits in the output
// register; if the receiver stalls, one finished response waits there and the
// following one is held inside until it is taken.
// Reset clears pointers, count, running sum and the response valid; the record memory
// is not cleared and needs no sweep, so requests are taken right after reset.
module fifo_with_min_and_mean #(
   parameter int DEPTH = fmm_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [15:0] temperature_in, [20:16] day_in, [24:21] month_in
   input  logic [fmm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] func
   input  logic [fmm_pkg::FUNC_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] temperature_out, [20:16] day_out, [24:21] month_out,
   // [40:25] minimum, [56:41] mean
   output logic [fmm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // [1:0] status
   output logic [fmm_pkg::STATUS_W-1:0]       rsp_tuser
);

   localparam int TW = fmm_pkg::TEMP_W;
   localparam int DW = fmm_pkg::DAY_W;
   localparam int MW = fmm_pkg::MONTH_W;

   fmm_pkg::cmd_type cmd;
   fmm_pkg::sts_type sts;

   logic signed [TW-1:0] temperature_in;
   logic [DW-1:0]        day_in;
   logic [MW-1:0]        month_in;
   logic signed [TW-1:0] temperature_out;
   logic [DW-1:0]        day_out;
   logic [MW-1:0]        month_out;
   logic signed [TW-1:0] minimum;
   logic signed [TW-1:0] mean;

   assign temperature_in = req_tdata[TW-1:0];
   assign day_in         = req_tdata[TW+DW-1:TW];
   assign month_in       = req_tdata[TW+DW+MW-1:TW+DW];

   assign rsp_tdata = {{(fmm_pkg::RSP_TDATA_W - fmm_pkg::RSP_FIELDS_W){1'b0}},
                       mean, minimum, month_out, day_out, temperature_out};

   fmm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   fmm_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .temperature_in  (temperature_in),
      .day_in          (day_in),
      .month_in        (month_in),
      .status          (rsp_tuser),
      .temperature_out (temperature_out),
      .day_out         (day_out),
      .month_out       (month_out),
      .minimum         (minimum),
      .mean            (mean)
   );

endmodule
